// ===== hdl/kvle_pkg.sv =====
// Shared types and constants for the key/value line extractor.
`timescale 1ns / 1ps

package kvle_pkg;

    typedef enum logic [1:0] {
        PH_KEY  = 2'd0,
        PH_EQ   = 2'd1,
        PH_LEAD = 2'd2,
        PH_VAL  = 2'd3
    } phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_KEY    = 2'd1;
    localparam logic [1:0] ST_NO_EQUALS = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [1:0] CFG_KEY_HIGH   = 2'd2;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [7:0] SAT8 = 8'hFF;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] value_char;
        logic [7:0] spaces_before;
        logic [1:0] status;
        logic [7:0] value_length;
        logic       last_of_run;
    } result_t;

endpackage

// ===== hdl/key_value_line_extractor.sv =====
// An accepted beat is registered, parsed and queued, and its first result is offered on
// out_*. Throughput: one input beat per cycle while the queue has room for two results;
// a line's last byte that also yields a value byte makes two results, so output drains
// one per cycle while out_ready is high. The single parse register feeding a 4-entry
// result queue sets the rate. Reset (rst_n low, async): key_length = 1, key bytes zero,
// parser searching for key, queue empty. Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module key_value_line_extractor #(
    parameter int KEY_MAX    = 16,
    parameter int LENGTH_MAX = 255
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  line_char,
    input  logic        line_end,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        item_kind,
    output logic [7:0]  value_char,
    output logic [7:0]  spaces_before,
    output logic [1:0]  status,
    output logic [7:0]  value_length,
    output logic        last_of_run
);

    localparam int KLW       = $clog2(KEY_MAX + 1);
    localparam int WIW       = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LEN_CAP_I = (LENGTH_MAX < 255) ? LENGTH_MAX : 255;
    localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_I);
    localparam logic [KLW-1:0] KEY_MAX_K = KLW'(KEY_MAX);
    localparam int QDEPTH = 4;
    localparam logic [2:0] QDEPTH_C = 3'(QDEPTH);

    // configuration
    logic [4:0]  key_length_reg;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;

    // input register
    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_end_reg;
    logic        s1_adv;

    // parser state
    kvle_pkg::phase_t phase_reg, phase_next, phase_after;
    logic [7:0]     win_reg [KEY_MAX];
    logic [7:0]     win_new [KEY_MAX];
    logic [KLW-1:0] chars_seen_reg, chars_seen_next, chars_new;
    logic [7:0]     pend_reg, pend_next;
    logic [7:0]     vcount_reg, vcount_next, vcount_after;

    logic [KLW-1:0] eff_len;
    logic [7:0]     key_byte [16];
    logic           key_hit;
    logic           is_sp;
    logic           emit_char;
    logic [7:0]     sp_out;
    logic [9:0]     cnt_sum;
    kvle_pkg::result_t res_char, res_end, res0, res1;
    logic [1:0]     n_push;

    // result queue
    kvle_pkg::result_t q_reg [QDEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] q_cnt_reg;
    logic [2:0] q_free;
    logic       pop;
    kvle_pkg::result_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= 5'd1;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                kvle_pkg::CFG_KEY_LENGTH: key_length_reg <= cfg_data[4:0];
                kvle_pkg::CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                kvle_pkg::CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        if (key_length_reg == 5'd0)
            eff_len = KLW'(1);
        else if (key_length_reg > 5'(KEY_MAX))
            eff_len = KEY_MAX_K;
        else
            eff_len = key_length_reg[KLW-1:0];
    end

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            key_byte[b]     = key_low_reg[8*b +: 8];
            key_byte[b + 8] = key_high_reg[8*b +: 8];
        end
    end

    // input register; advances only when the queue can take two results
    assign q_free   = QDEPTH_C - q_cnt_reg;
    assign s1_adv   = s1_valid_reg && (q_free >= 3'd2);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= line_char;
            s1_end_reg  <= line_end;
        end
    end

    // window after shifting in the current byte, and the parallel key compare
    always_comb
    begin
        logic [KLW-1:0] idx;
        idx = '0;
        win_new[0] = s1_char_reg;
        for (int i = 1; i < KEY_MAX; i++)
            win_new[i] = win_reg[i - 1];
        chars_new = (chars_seen_reg < KEY_MAX_K) ? chars_seen_reg + KLW'(1) : chars_seen_reg;
        key_hit = (chars_new >= eff_len);
        for (int j = 0; j < KEY_MAX; j++)
        begin
            if (KLW'(j) < eff_len)
            begin
                idx = eff_len - KLW'(1) - KLW'(j);
                if (win_new[idx[WIW-1:0]] != key_byte[j])
                    key_hit = 1'b0;
            end
        end
    end

    assign is_sp = (s1_char_reg == kvle_pkg::CH_SP);

    // next phase
    always_comb
    begin
        phase_after = phase_reg;
        case (phase_reg)
            kvle_pkg::PH_KEY:
                if (key_hit)
                    phase_after = kvle_pkg::PH_EQ;
            kvle_pkg::PH_EQ:
                if (s1_char_reg == kvle_pkg::CH_EQ)
                    phase_after = kvle_pkg::PH_LEAD;
            kvle_pkg::PH_LEAD, kvle_pkg::PH_VAL:
                if (!is_sp)
                    phase_after = kvle_pkg::PH_VAL;
            default:
                phase_after = kvle_pkg::PH_KEY;
        endcase
        if (!s1_adv)
            phase_next = phase_reg;
        else if (s1_end_reg)
            phase_next = kvle_pkg::PH_KEY;
        else
            phase_next = phase_after;
    end

    // counters and results
    always_comb
    begin
        emit_char = ((phase_reg == kvle_pkg::PH_LEAD) || (phase_reg == kvle_pkg::PH_VAL))
                    && !is_sp;
        sp_out    = (phase_reg == kvle_pkg::PH_VAL) ? pend_reg : 8'd0;
        cnt_sum   = 10'(vcount_reg) + 10'(sp_out) + 10'd1;

        vcount_after = vcount_reg;
        pend_next    = pend_reg;
        if (emit_char)
        begin
            vcount_after = (cnt_sum > 10'(LEN_CAP)) ? LEN_CAP : cnt_sum[7:0];
            pend_next    = 8'd0;
        end
        else if (is_sp && (phase_reg == kvle_pkg::PH_VAL) && (pend_reg != kvle_pkg::SAT8))
            pend_next = pend_reg + 8'd1;

        res_char               = '0;
        res_char.value_char    = s1_char_reg;
        res_char.spaces_before = sp_out;
        res_char.last_of_run   = !s1_end_reg;

        res_end             = '0;
        res_end.item_kind   = 1'b1;
        res_end.last_of_run = 1'b1;
        case (phase_after)
            kvle_pkg::PH_KEY:  res_end.status = kvle_pkg::ST_NO_KEY;
            kvle_pkg::PH_EQ:   res_end.status = kvle_pkg::ST_NO_EQUALS;
            kvle_pkg::PH_LEAD: res_end.status = kvle_pkg::ST_EMPTY;
            default:
            begin
                res_end.status       = kvle_pkg::ST_OK;
                res_end.value_length = vcount_after;
            end
        endcase

        res0   = emit_char ? res_char : res_end;
        res1   = res_end;
        n_push = s1_adv ? (2'(emit_char) + 2'(s1_end_reg)) : 2'd0;

        chars_seen_next = chars_seen_reg;
        vcount_next     = vcount_reg;
        if (s1_adv)
        begin
            if (s1_end_reg)
            begin
                chars_seen_next = '0;
                vcount_next     = 8'd0;
                pend_next       = 8'd0;
            end
            else
            begin
                if (phase_reg == kvle_pkg::PH_KEY)
                    chars_seen_next = chars_new;
                vcount_next = vcount_after;
            end
        end
        else
            pend_next = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= kvle_pkg::PH_KEY;
            chars_seen_reg <= '0;
            pend_reg       <= 8'd0;
            vcount_reg     <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            chars_seen_reg <= chars_seen_next;
            pend_reg       <= pend_next;
            vcount_reg     <= vcount_next;
        end
    end

    // window entries are only compared once written in the current line
    always_ff @(posedge clk)
    begin
        if (s1_adv && (phase_reg == kvle_pkg::PH_KEY))
        begin
            for (int i = 0; i < KEY_MAX; i++)
                win_reg[i] <= win_new[i];
        end
    end

    // result queue
    assign pop  = out_valid && out_ready;
    assign head = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (n_push == 2'd2)
            q_reg[wr_ptr_reg + 2'd1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            q_cnt_reg <= q_cnt_reg + 3'(n_push) - 3'(pop);
        end
    end

    assign out_valid     = (q_cnt_reg != 3'd0);
    assign item_kind     = head.item_kind;
    assign value_char    = head.value_char;
    assign spaces_before = head.spaces_before;
    assign status        = head.status;
    assign value_length  = head.value_length;
    assign last_of_run   = head.last_of_run;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= QDEPTH_C)
        else $error("result queue overflow");

    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_end_reg |=> phase_reg == kvle_pkg::PH_KEY && chars_seen_reg == '0
            && vcount_reg == 8'd0 && pend_reg == 8'd0)
        else $error("line state not cleared after end of line");

    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind |-> last_of_run)
        else $error("end report not marked last");

    a_length_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (value_length != 8'd0) |-> item_kind && (status == kvle_pkg::ST_OK))
        else $error("length on a non-ok result");

    a_no_space_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !item_kind |-> value_char != kvle_pkg::CH_SP)
        else $error("space emitted as value byte");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for key_value_line_extractor: random key=value lines checked against a line parser.
`timescale 1ns / 1ps

module tb_top;

    localparam int KEY_SPAN       = 16;
    localparam int LEN_CAP        = 255;
    localparam int PHASE_ITEMS    = 405;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    // register index past the last real one; writes to it must be dropped
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef enum {
        LN_GOOD, LN_ONE, LN_EMPTY, LN_NO_EQ, LN_NOISE, LN_LONG_GAP, LN_LONG_VALUE
    } line_kind_t;

    // Parser mirror: tracks key/value state per line and queues the beats it should emit.
    class kv_line_tracker;
        kvle_pkg::phase_t  ph;
        logic [7:0]        window [KEY_SPAN];
        int unsigned       seen;
        int unsigned       gap;
        int unsigned       vlen;
        logic [4:0]        key_len;
        logic [63:0]       key_lo;
        logic [63:0]       key_hi;
        kvle_pkg::result_t due [$];
        int unsigned       errors;

        function new();
            key_len = 5'd1;
            key_lo  = '0;
            key_hi  = '0;
            errors  = 0;
            clear_line();
        endfunction

        function void clear_line();
            ph = kvle_pkg::PH_KEY;
            foreach (window[i]) window[i] = 8'h00;
            seen = 0;
            gap  = 0;
            vlen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] d);
            case (idx)
                kvle_pkg::CFG_KEY_LENGTH: key_len = d[4:0];
                kvle_pkg::CFG_KEY_LOW:    key_lo  = d;
                kvle_pkg::CFG_KEY_HIGH:   key_hi  = d;
                default: ;
            endcase
        endfunction

        function int unsigned key_span();
            int unsigned k;
            k = key_len;
            if (k < 1) k = 1;
            if (k > KEY_SPAN) k = KEY_SPAN;
            return k;
        endfunction

        function logic [7:0] key_at(int unsigned j);
            return (j < 8) ? key_lo[8*j +: 8] : key_hi[8*(j-8) +: 8];
        endfunction

        // window[0] is the newest byte, so key byte j sits k-1-j back
        function bit key_hit();
            int unsigned k;
            k = key_span();
            if (seen < k) return 1'b0;
            for (int unsigned j = 0; j < k; j++)
                if (window[k-1-j] != key_at(j)) return 1'b0;
            return 1'b1;
        endfunction

        function void take_char(logic [7:0] c, logic last);
            kvle_pkg::result_t made [$];
            kvle_pkg::result_t r;
            int unsigned       sp;
            case (ph)
                kvle_pkg::PH_KEY:
                begin
                    for (int i = KEY_SPAN - 1; i > 0; i--) window[i] = window[i-1];
                    window[0] = c;
                    if (seen < KEY_SPAN) seen++;
                    if (key_hit()) ph = kvle_pkg::PH_EQ;
                end
                kvle_pkg::PH_EQ: if (c == kvle_pkg::CH_EQ) ph = kvle_pkg::PH_LEAD;
                default:
                begin
                    if (c == kvle_pkg::CH_SP)
                    begin
                        // leading spaces are dropped, interior ones held back
                        if (ph == kvle_pkg::PH_VAL && gap < kvle_pkg::SAT8) gap++;
                    end
                    else
                    begin
                        sp = (ph == kvle_pkg::PH_VAL) ? gap : 0;
                        vlen = (vlen + sp + 1 > LEN_CAP) ? LEN_CAP : vlen + sp + 1;
                        r = '0;
                        r.value_char    = c;
                        r.spaces_before = sp[7:0];
                        made.push_back(r);
                        gap = 0;
                        ph  = kvle_pkg::PH_VAL;
                    end
                end
            endcase
            if (last)
            begin
                r = '0;
                r.item_kind = 1'b1;
                case (ph)
                    kvle_pkg::PH_KEY:  r.status = kvle_pkg::ST_NO_KEY;
                    kvle_pkg::PH_EQ:   r.status = kvle_pkg::ST_NO_EQUALS;
                    kvle_pkg::PH_LEAD: r.status = kvle_pkg::ST_EMPTY;
                    default:
                    begin
                        r.status       = kvle_pkg::ST_OK;
                        r.value_length = vlen[7:0];
                    end
                endcase
                made.push_back(r);
                clear_line();
            end
            if (made.size() > 0) made[made.size()-1].last_of_run = 1'b1;
            foreach (made[i]) due.push_back(made[i]);
        endfunction

        function string show(kvle_pkg::result_t r);
            return $sformatf("kind=%0d char=%02h sp=%0d st=%0d len=%0d last=%0d",
                             r.item_kind, r.value_char, r.spaces_before, r.status,
                             r.value_length, r.last_of_run);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
        endfunction

        function void check_beat(kvle_pkg::result_t got);
            kvle_pkg::result_t want;
            if (due.size() == 0)
            begin
                flag({"unexpected beat ", show(got)});
                return;
            end
            want = due.pop_front();
            if (got.item_kind !== want.item_kind || got.value_char !== want.value_char ||
                got.spaces_before !== want.spaces_before || got.status !== want.status ||
                got.value_length !== want.value_length ||
                got.last_of_run !== want.last_of_run)
                flag({"expected ", show(want), " got ", show(got)});
        endfunction

        function void drain_check();
            while (due.size() != 0) flag({"missing beat ", show(due.pop_front())});
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [63:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [7:0]  line_char     = '0;
    logic        line_end      = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        item_kind;
    logic [7:0]  value_char;
    logic [7:0]  spaces_before;
    logic [1:0]  status;
    logic [7:0]  value_length;
    logic        last_of_run;

    kv_line_tracker    tracker = new();
    kvle_pkg::result_t seen_beat;
    logic [7:0]        key_text [$];
    logic [7:0]        line_buf [$];
    int unsigned       sent_count   = 0;
    int unsigned       idle_cycles  = 0;
    int                tx_idle_pct  = 0;
    int                rx_stall_pct = 0;
    bit                hold_pending = 1'b0;

    key_value_line_extractor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .line_char    (line_char),
        .line_end     (line_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .item_kind    (item_kind),
        .value_char   (value_char),
        .spaces_before(spaces_before),
        .status       (status),
        .value_length (value_length),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input beats are predicted before output beats of the same edge are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
            if (in_valid && in_ready) tracker.take_char(line_char, line_end);
            if (out_valid && out_ready)
            begin
                seen_beat.item_kind     = item_kind;
                seen_beat.value_char    = value_char;
                seen_beat.spaces_before = spaces_before;
                seen_beat.status        = status;
                seen_beat.value_length  = value_length;
                seen_beat.last_of_run   = last_of_run;
                tracker.check_beat(seen_beat);
            end
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("key_value_line_extractor: mismatch");
                    $finish;
                end
            end
        end
    end

    // output side: random stalls, or one long hold-off to back the block up
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [7:0] pick_byte(input logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom_range(255));
        return (v == avoid) ? ~avoid : v;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [7:0] c, input logic e);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        line_char <= c;
        line_end  <= e;
        sent_count++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_beat(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic text_line(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
        send_line();
    endtask

    task automatic compose_line(input line_kind_t kind);
        int n;
        line_buf.delete();
        if (kind == LN_NOISE)
        begin
            n = $urandom_range(1, 20);
            repeat (n) line_buf.push_back(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom));
        foreach (key_text[i]) line_buf.push_back(key_text[i]);
        if (kind == LN_NO_EQ)
        begin
            repeat ($urandom_range(0, 8)) line_buf.push_back(pick_byte(kvle_pkg::CH_EQ));
            return;
        end
        repeat ($urandom_range(0, 3)) line_buf.push_back(pick_byte(kvle_pkg::CH_EQ));
        line_buf.push_back(kvle_pkg::CH_EQ);
        repeat ($urandom_range(0, 3)) line_buf.push_back(kvle_pkg::CH_SP);
        case (kind)
            LN_ONE:   line_buf.push_back(pick_byte(kvle_pkg::CH_SP));
            LN_EMPTY: ;
            LN_LONG_GAP:
            begin
                // interior run past the spaces_before and length saturation points
                line_buf.push_back(pick_byte(kvle_pkg::CH_SP));
                repeat (270) line_buf.push_back(kvle_pkg::CH_SP);
                line_buf.push_back(pick_byte(kvle_pkg::CH_SP));
            end
            LN_LONG_VALUE: repeat (270) line_buf.push_back(pick_byte(kvle_pkg::CH_SP));
            default:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0) repeat ($urandom_range(0, 3)) line_buf.push_back(kvle_pkg::CH_SP);
                    line_buf.push_back(pick_byte(kvle_pkg::CH_SP));
                end
            end
        endcase
        repeat ($urandom_range(0, 3)) line_buf.push_back(kvle_pkg::CH_SP);
    endtask

    task automatic cfg_beat(input logic [1:0] idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // random upper bits in the length word must be ignored by the block
    task automatic program_key(input logic [4:0] len, input logic [63:0] lo,
                               input logic [63:0] hi);
        logic [63:0] len_word;
        len_word      = {$urandom, $urandom};
        len_word[4:0] = len;
        cfg_beat(kvle_pkg::CFG_KEY_LENGTH, len_word);
        cfg_beat(kvle_pkg::CFG_KEY_LOW, lo);
        cfg_beat(kvle_pkg::CFG_KEY_HIGH, hi);
        cfg_beat(CFG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        key_text.delete();
        for (int j = 0; j < tracker.key_span(); j++) key_text.push_back(tracker.key_at(j));
    endtask

    // drop valid, wait for every predicted beat, then give the pipeline time to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int tx, input int rx, input bit squeeze,
                             input line_kind_t opener);
        int unsigned stop_at;
        int unsigned roll;
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        if (squeeze) hold_pending = 1'b1;
        stop_at = sent_count + PHASE_ITEMS;
        compose_line(opener);
        send_line();
        while (sent_count < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 55)      compose_line(LN_GOOD);
            else if (roll < 63) compose_line(LN_ONE);
            else if (roll < 71) compose_line(LN_EMPTY);
            else if (roll < 81) compose_line(LN_NO_EQ);
            else                compose_line(LN_NOISE);
            send_line();
        end
        settle();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset key is a single zero byte: "\0=q"
        line_buf = '{8'h00, kvle_pkg::CH_EQ, 8'h71};
        send_line();
        settle();

        // key "ab" with junk in the unused key bytes
        program_key(5'd2, {$urandom, 16'($urandom), 8'h62, 8'h61}, {$urandom, $urandom});
        text_line("ab=x");
        text_line("ab= ");
        text_line("ab=");
        text_line("xab");
        text_line("a");
        // extreme byte values inside the value, interior and trailing space
        line_buf = '{8'h61, 8'h62, kvle_pkg::CH_EQ, 8'hFF, kvle_pkg::CH_SP, 8'h00,
                     kvle_pkg::CH_SP};
        send_line();
        settle();

        program_key(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(0, 0, 1'b1, LN_GOOD);
        program_key(5'd0, {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(81, 0, 1'b0, LN_LONG_GAP);
        program_key(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(0, 81, 1'b0, LN_LONG_VALUE);
        program_key(5'($urandom_range(2, 15)), {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(28, 28, 1'b0, LN_GOOD);

        tracker.drain_check();
        if (tracker.errors == 0)
            $display("key_value_line_extractor: match");
        else
            $display("key_value_line_extractor: mismatch");
        $finish;
    end

endmodule
